/* sv/general_purpose_timer_regs_macros.svh */
// Assertion macros for the timer register block.
`ifndef GENERAL_PURPOSE_TIMER_REGS_MACROS_SVH
`define GENERAL_PURPOSE_TIMER_REGS_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define GPTR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define GPTR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* sv/gptr_pkg.sv */
// Types and constants for the timer register block.
`default_nettype none
package gptr_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } t_op;

    typedef logic [9:0] t_reg_idx;

    localparam t_reg_idx REG_CTRL     = 10'd0;
    localparam t_reg_idx REG_PRESCALE = 10'd1;
    localparam t_reg_idx REG_STATUS   = 10'd2;
    localparam t_reg_idx REG_IRQ_EN   = 10'd3;
    localparam t_reg_idx REG_CMP1     = 10'd4;
    localparam t_reg_idx REG_CMP2     = 10'd5;
    localparam t_reg_idx REG_CMP3     = 10'd6;
    localparam t_reg_idx REG_CAPT1    = 10'd7;
    localparam t_reg_idx REG_CAPT2    = 10'd8;
    localparam t_reg_idx REG_COUNT    = 10'd9;

    localparam int CTL_EN_BIT    = 0;
    localparam int CTL_ENMOD_BIT = 1;
    localparam int CTL_FRR_BIT   = 9;
    localparam int CTL_SWR_BIT   = 15;

    localparam logic [31:0] CTL_CLEAR_MASK = 32'h0000_FC00;

    localparam logic [2:0] CLKSRC_A = 3'd1;
    localparam logic [2:0] CLKSRC_B = 3'd2;
    localparam logic [2:0] CLKSRC_C = 3'd4;

    localparam int ST_OF1_BIT  = 0;
    localparam int ST_ROV_BIT  = 5;
    localparam int IE_OF1_BIT  = 0;
    localparam int IE_ROV_BIT  = 5;
    localparam int IE_WIDTH    = 6;

endpackage
`default_nettype wire

/* sv/general_purpose_timer_regs.sv */
// Timer register block: bus reads, bus writes and clock ticks as one item stream.
`default_nettype none
`include "general_purpose_timer_regs_macros.svh"

// Takes one item per cycle while o_in_stall is low and returns one result per
// item. The item is captured in an input register; when the output can advance,
// the timer state and the result register update together. The counter
// increment, the compare and the register decode fit between those registers.
// Each result carries the read data (zero unless the item is a read of a
// decoded register; CAPT1 and CAPT2 read zero) and the interrupt level after
// the item. A new item is taken while a result still waits to be collected, as
// long as the input register is free.
module general_purpose_timer_regs #(
    parameter int COUNT_WIDTH    = 32,
    parameter int PRESCALE_WIDTH = 12
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_op,
    input  wire gptr_pkg::t_reg_idx i_reg_index,
    input  wire logic [31:0]        i_write_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [31:0]             o_read_data,
    output logic                    o_irq_out
);
    import gptr_pkg::*;

    logic                      r_in_valid;
    logic [1:0]                r_in_op;
    t_reg_idx                  r_in_idx;
    logic [31:0]               r_in_data;

    logic                      r_out_valid;
    logic [31:0]               r_rd;
    logic                      r_irq;

    logic [31:0]               r_ctrl,  n_ctrl;
    logic [PRESCALE_WIDTH-1:0] r_psv,   n_psv;
    logic [PRESCALE_WIDTH-1:0] r_psc,   n_psc;
    logic                      r_of1,   n_of1;
    logic                      r_rov,   n_rov;
    logic [IE_WIDTH-1:0]       r_ie,    n_ie;
    logic [COUNT_WIDTH-1:0]    r_cmp,   n_cmp;
    logic [COUNT_WIDTH-1:0]    r_cnt,   n_cnt;
    logic [31:0]               n_rd;
    logic                      n_irq;

    logic                      advance;
    logic                      process;
    logic                      in_accept;
    logic [2:0]                clk_src;
    logic                      src_ok;
    logic [COUNT_WIDTH-1:0]    cnt_next;
    logic [63:0]               cnt_wide;
    logic [63:0]               cmp_wide;

    assign advance    = !r_out_valid || !i_out_stall;
    assign process    = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign clk_src  = r_ctrl[8:6];
    assign src_ok   = (clk_src == CLKSRC_A) || (clk_src == CLKSRC_B) || (clk_src == CLKSRC_C);
    assign cnt_wide = 64'(r_cnt);
    assign cmp_wide = 64'(r_cmp);

    always_comb begin
        if (r_ctrl[CTL_FRR_BIT]) begin
            cnt_next = (&r_cnt) ? '0 : r_cnt + COUNT_WIDTH'(1);
        end else begin
            cnt_next = (r_cnt == r_cmp) ? '0 : r_cnt + COUNT_WIDTH'(1);
        end
    end

    always_comb begin
        n_ctrl = r_ctrl;
        n_psv  = r_psv;
        n_psc  = r_psc;
        n_of1  = r_of1;
        n_rov  = r_rov;
        n_ie   = r_ie;
        n_cmp  = r_cmp;
        n_cnt  = r_cnt;
        n_rd   = '0;
        if (process) begin
            case (r_in_op)
                OP_TICK: begin
                    if (r_ctrl[CTL_EN_BIT] && src_ok) begin
                        if (r_psc >= r_psv) begin
                            n_psc = '0;
                            n_cnt = cnt_next;
                            if (r_ctrl[CTL_FRR_BIT] && (&r_cnt)) begin
                                n_rov = 1'b1;
                            end
                            if (cnt_next == r_cmp) begin
                                n_of1 = 1'b1;
                            end
                        end else begin
                            n_psc = r_psc + PRESCALE_WIDTH'(1);
                        end
                    end
                end
                OP_READ: begin
                    unique case (r_in_idx)
                        REG_CTRL:            n_rd = r_ctrl;
                        REG_PRESCALE:        n_rd = 32'(r_psv);
                        REG_STATUS: begin
                            n_rd[ST_OF1_BIT] = r_of1;
                            n_rd[ST_ROV_BIT] = r_rov;
                        end
                        REG_IRQ_EN:          n_rd = 32'(r_ie);
                        REG_CMP1:            n_rd = cmp_wide[31:0];
                        REG_CMP2, REG_CMP3:  n_rd = '1;
                        REG_COUNT:           n_rd = cnt_wide[31:0];
                        default:             n_rd = '0;
                    endcase
                end
                OP_WRITE: begin
                    unique case (r_in_idx)
                        REG_CTRL: begin
                            if (r_in_data[CTL_SWR_BIT]) begin
                                n_cnt = '0;
                                n_psc = '0;
                                n_of1 = 1'b0;
                                n_rov = 1'b0;
                                n_psv = '0;
                                n_ie  = '0;
                                n_cmp = '1;
                            end
                            n_ctrl = r_in_data & ~CTL_CLEAR_MASK;
                            if (!r_ctrl[CTL_EN_BIT] && r_in_data[CTL_EN_BIT]
                                && r_in_data[CTL_ENMOD_BIT]) begin
                                n_cnt = '0;
                                n_psc = '0;
                            end
                        end
                        REG_PRESCALE: n_psv = PRESCALE_WIDTH'(r_in_data);
                        REG_STATUS: begin
                            if (r_in_data[ST_OF1_BIT]) n_of1 = 1'b0;
                            if (r_in_data[ST_ROV_BIT]) n_rov = 1'b0;
                        end
                        REG_IRQ_EN: n_ie = r_in_data[IE_WIDTH-1:0];
                        REG_CMP1: begin
                            n_cmp = COUNT_WIDTH'(r_in_data);
                            if (!r_ctrl[CTL_FRR_BIT]) begin
                                n_cnt = '0;
                                n_psc = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
        n_irq = n_ctrl[CTL_EN_BIT]
              && ((n_of1 && n_ie[IE_OF1_BIT]) || (n_rov && n_ie[IE_ROV_BIT]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
            r_psv  <= '0;
            r_psc  <= '0;
            r_of1  <= 1'b0;
            r_rov  <= 1'b0;
            r_ie   <= '0;
            r_cmp  <= '1;
            r_cnt  <= '0;
        end else begin
            r_ctrl <= n_ctrl;
            r_psv  <= n_psv;
            r_psc  <= n_psc;
            r_of1  <= n_of1;
            r_rov  <= n_rov;
            r_ie   <= n_ie;
            r_cmp  <= n_cmp;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept || (r_in_valid && !advance);
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_op   <= i_op;
            r_in_idx  <= i_reg_index;
            r_in_data <= i_write_data;
        end
        if (process) begin
            r_rd  <= n_rd;
            r_irq <= n_irq;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_rd;
    assign o_irq_out   = r_irq;

    `GPTR_ASSERT_NOW(a_irq_needs_en, o_out_valid && o_irq_out, r_ctrl[CTL_EN_BIT],
        "interrupt shown while timer disabled")
    `GPTR_ASSERT_NEXT(a_hold_state, r_out_valid && i_out_stall, $stable(r_cnt) && $stable(r_ctrl),
        "timer state moved while result held")
    `GPTR_ASSERT_NEXT(a_rd_zero, process && (r_in_op != OP_READ), o_read_data == 32'd0,
        "read data non-zero for a non-read item")
    `GPTR_ASSERT_NEXT(a_in_kept, o_in_stall, r_in_valid,
        "pending item dropped under stall")

endmodule
`default_nettype wire

/* tb/sv/gptr_result_checker.sv */
// Checker for the timer register block: predicts each result and compares it.
module gptr_result_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_op,
    input  gptr_pkg::t_reg_idx i_reg_index,
    input  logic [31:0]        i_write_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [31:0]        i_read_data,
    input  logic               i_irq_out,
    output int                 o_mismatch_count,
    output int                 o_outstanding
);
    import gptr_pkg::*;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq;
    } t_timer_result;

    t_timer_result pending_results[$];

    logic [31:0]         ctl;
    logic [11:0]         psc_val;
    logic [11:0]         psc_cnt;
    logic                flag_of1;
    logic                flag_rov;
    logic [IE_WIDTH-1:0] irq_en;
    logic [31:0]         compare_one;
    logic [31:0]         up_count;

    int mismatch_count = 0;
    int outstanding_count = 0;

    assign o_mismatch_count = mismatch_count;
    assign o_outstanding    = outstanding_count;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: %s got %h want %h", what, got, want);
        mismatch_count++;
    endtask

    task automatic timer_soft_clear();
        up_count    = '0;
        psc_cnt     = '0;
        flag_of1    = 1'b0;
        flag_rov    = 1'b0;
        psc_val     = '0;
        irq_en      = '0;
        compare_one = '1;
    endtask

    task automatic count_up_one();
        if (ctl[CTL_FRR_BIT]) begin
            if (up_count == '1) begin
                up_count = '0;
                flag_rov = 1'b1;
            end else begin
                up_count = up_count + 32'd1;
            end
        end else if (up_count == compare_one) begin
            up_count = '0;
        end else begin
            up_count = up_count + 32'd1;
        end
        if (up_count == compare_one) flag_of1 = 1'b1;
    endtask

    task automatic timer_tick();
        logic [2:0] src;
        src = ctl[8:6];
        if (ctl[CTL_EN_BIT] && (src == CLKSRC_A || src == CLKSRC_B || src == CLKSRC_C)) begin
            if (psc_cnt >= psc_val) begin
                psc_cnt = '0;
                count_up_one();
            end else begin
                psc_cnt = psc_cnt + 12'd1;
            end
        end
    endtask

    function automatic logic [31:0] register_value(input t_reg_idx idx);
        logic [31:0] v;
        v = '0;
        case (idx)
            REG_CTRL:     v = ctl;
            REG_PRESCALE: v[11:0] = psc_val;
            REG_STATUS: begin
                v[ST_OF1_BIT] = flag_of1;
                v[ST_ROV_BIT] = flag_rov;
            end
            REG_IRQ_EN:   v[IE_WIDTH-1:0] = irq_en;
            REG_CMP1:     v = compare_one;
            REG_CMP2:     v = '1;
            REG_CMP3:     v = '1;
            REG_COUNT:    v = up_count;
            default:      v = '0;
        endcase
        return v;
    endfunction

    task automatic register_write(input t_reg_idx idx, input logic [31:0] data);
        logic old_en;
        case (idx)
            REG_CTRL: begin
                old_en = ctl[CTL_EN_BIT];
                if (data[CTL_SWR_BIT]) timer_soft_clear();
                ctl = data & ~CTL_CLEAR_MASK;
                if (!old_en && data[CTL_EN_BIT] && data[CTL_ENMOD_BIT]) begin
                    up_count = '0;
                    psc_cnt  = '0;
                end
            end
            REG_PRESCALE: psc_val = data[11:0];
            REG_STATUS: begin
                if (data[ST_OF1_BIT]) flag_of1 = 1'b0;
                if (data[ST_ROV_BIT]) flag_rov = 1'b0;
            end
            REG_IRQ_EN: irq_en = data[IE_WIDTH-1:0];
            REG_CMP1: begin
                compare_one = data;
                if (!ctl[CTL_FRR_BIT]) begin
                    up_count = '0;
                    psc_cnt  = '0;
                end
            end
            default: ;
        endcase
    endtask

    function automatic logic irq_level();
        return ctl[CTL_EN_BIT] && ((flag_of1 && irq_en[IE_OF1_BIT]) ||
                                   (flag_rov && irq_en[IE_ROV_BIT]));
    endfunction

    task automatic timer_apply_item(input logic [1:0] op, input t_reg_idx idx,
                                    input logic [31:0] data, output t_timer_result r);
        r.read_data = '0;
        case (op)
            OP_TICK:  timer_tick();
            OP_READ:  r.read_data = register_value(idx);
            OP_WRITE: register_write(idx, data);
            default: ;
        endcase
        r.irq = irq_level();
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_timer_result want;
        t_timer_result predicted;
        if (!i_rst_n) begin
            ctl = '0;
            timer_soft_clear();
            pending_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no item outstanding", i_read_data, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (i_read_data !== want.read_data)
                        report_mismatch("read_data", i_read_data, want.read_data);
                    if (i_irq_out !== want.irq)
                        report_mismatch("irq_out", {31'd0, i_irq_out}, {31'd0, want.irq});
                end
            end
            if (i_in_valid && !i_in_stall) begin
                timer_apply_item(i_op, i_reg_index, i_write_data, predicted);
                pending_results.push_back(predicted);
            end
        end
        outstanding_count <= pending_results.size();
    end
endmodule

/* tb/sv/tb_general_purpose_timer_regs.sv */
// Testbench top for the timer register block: stimulus, stall pattern and verdict.
module tb_general_purpose_timer_regs;
    import gptr_pkg::*;

    localparam logic [1:0]  OP_RESERVED      = 2'd3;
    localparam t_reg_idx    REG_LAST_OFFSET  = 10'h3FF;
    localparam logic [31:0] CTRL_RUN_RESTART = 32'h0000_0041;
    localparam logic [31:0] CTRL_ENMOD_START = 32'h0000_0283;
    localparam int          RANDOM_ITEMS     = 800;
    localparam int          WATCHDOG_LIMIT   = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [1:0]  in_op = OP_TICK;
    t_reg_idx    in_reg_index = '0;
    logic [31:0] in_write_data = '0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [31:0] read_data;
    logic        irq_out;

    int mismatch_count;
    int outstanding;
    int burst_left = 0;
    int idle_cycles = 0;
    int stall_mode = 0;
    int stall_phase_left = 0;
    int stall_cycle = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    general_purpose_timer_regs dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_op         (in_op),
        .i_reg_index  (in_reg_index),
        .i_write_data (in_write_data),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_read_data  (read_data),
        .o_irq_out    (irq_out)
    );

    gptr_result_checker timer_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_op             (in_op),
        .i_reg_index      (in_reg_index),
        .i_write_data     (in_write_data),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_read_data      (read_data),
        .i_irq_out        (irq_out),
        .o_mismatch_count (mismatch_count),
        .o_outstanding    (outstanding)
    );

    always @(posedge i_clk) begin
        stall_cycle <= stall_cycle + 1;
        if (stall_phase_left == 0) begin
            stall_mode       <= $urandom_range(0, 3);
            stall_phase_left <= $urandom_range(20, 150);
        end else begin
            stall_phase_left <= stall_phase_left - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 99) < 35);
            2:       out_stall <= ((stall_cycle % 5) < 2);
            default: out_stall <= ($urandom_range(0, 15) == 0) ? ~out_stall : out_stall;
        endcase
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input logic [1:0] op, input t_reg_idx idx,
                             input logic [31:0] data);
        int gap;
        in_valid      <= 1'b1;
        in_op         <= op;
        in_reg_index  <= idx;
        in_write_data <= data;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    function automatic logic [31:0] random_ctrl();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 4))
            0:       v[8:6] = CLKSRC_A;
            1:       v[8:6] = CLKSRC_B;
            2:       v[8:6] = CLKSRC_C;
            default: v[8:6] = 3'($urandom_range(0, 7));
        endcase
        v[CTL_EN_BIT]  = ($urandom_range(0, 4) != 0);
        v[CTL_SWR_BIT] = ($urandom_range(0, 15) == 0);
        return v;
    endfunction

    initial begin
        int          pick;
        logic [31:0] data;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(OP_READ, REG_LAST_OFFSET, '0);
        send_item(OP_RESERVED, REG_CTRL, '1);
        send_item(OP_WRITE, REG_CTRL, '1);
        send_item(OP_READ, REG_CTRL, '0);
        send_item(OP_WRITE, REG_CMP3, '0);
        send_item(OP_WRITE, REG_COUNT, 32'h1234_5678);
        send_item(OP_READ, REG_CMP3, '0);
        send_item(OP_WRITE, REG_CTRL, CTRL_RUN_RESTART);
        send_item(OP_WRITE, REG_CMP1, 32'd2);
        send_item(OP_WRITE, REG_IRQ_EN, '1);
        repeat (4) send_item(OP_TICK, REG_CTRL, '0);
        send_item(OP_WRITE, REG_STATUS, '1);
        send_item(OP_WRITE, REG_PRESCALE, 32'd3);
        repeat (2) send_item(OP_TICK, REG_CTRL, '0);
        send_item(OP_WRITE, REG_PRESCALE, '0);
        send_item(OP_TICK, REG_CTRL, '0);
        send_item(OP_WRITE, REG_CTRL, '0);
        send_item(OP_TICK, REG_CTRL, '0);
        send_item(OP_WRITE, REG_CTRL, CTRL_ENMOD_START);
        send_item(OP_TICK, REG_CTRL, '0);
        send_item(OP_READ, REG_COUNT, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            data = $urandom();
            if (pick < 48) begin
                send_item(OP_TICK, t_reg_idx'($urandom()), data);
            end else if (pick < 66) begin
                send_item(OP_READ, t_reg_idx'($urandom_range(0, 9)), data);
            end else if (pick < 70) begin
                send_item(OP_READ, t_reg_idx'($urandom()), data);
            end else if (pick < 78) begin
                send_item(OP_WRITE, REG_CTRL, random_ctrl());
            end else if (pick < 82) begin
                send_item(OP_WRITE, REG_PRESCALE,
                          ($urandom_range(0, 7) == 0) ? data : $urandom_range(0, 3));
            end else if (pick < 86) begin
                send_item(OP_WRITE, REG_STATUS, data);
            end else if (pick < 89) begin
                send_item(OP_WRITE, REG_IRQ_EN, data);
            end else if (pick < 94) begin
                send_item(OP_WRITE, REG_CMP1,
                          ($urandom_range(0, 7) == 0) ? data : $urandom_range(0, 24));
            end else if (pick < 96) begin
                send_item(OP_WRITE, t_reg_idx'($urandom_range(0, 15)), data);
            end else if (pick < 98) begin
                send_item(OP_WRITE, t_reg_idx'($urandom()), data);
            end else begin
                send_item(OP_RESERVED, t_reg_idx'($urandom()), data);
            end
        end

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
